// ===== design/tbml_pkg.sv =====
package tbml_pkg;

  localparam logic [31:0] TOKENS_PER_MESSAGE = 32'd1000;

  localparam int unsigned CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    VERDICT_FILTERED = 2'd0,
    VERDICT_PASSED   = 2'd1,
    VERDICT_DROPPED  = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    REG_LEVEL_CAP   = 2'd0,
    REG_REFILL_RATE = 2'd1,
    REG_BURST_LIMIT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  level_cap;
    logic [31:0] refill_rate;
    logic [31:0] burst_limit;
  } cfg_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        report_drops;
    logic [31:0] dropped_count;
    logic [31:0] dropped_span;
  } result_t;

endpackage

// ===== design/tbml_cfg.sv =====
module tbml_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tbml_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output tbml_pkg::cfg_t                   cfg
);
  import tbml_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_cap   <= 3'd7;
      cfg.refill_rate <= 32'd0;
      cfg.burst_limit <= 32'd0;
    end else if (wr_en) begin
      case (idx)
        REG_LEVEL_CAP:   cfg.level_cap   <= pwdata[2:0];
        REG_REFILL_RATE: cfg.refill_rate <= pwdata;
        REG_BURST_LIMIT: cfg.burst_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEVEL_CAP:   prdata = {29'd0, cfg.level_cap};
      REG_REFILL_RATE: prdata = cfg.refill_rate;
      REG_BURST_LIMIT: prdata = cfg.burst_limit;
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/tbml_core.sv =====
module tbml_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [2:0]        level,
  input  logic [31:0]       now,
  input  tbml_pkg::cfg_t    cfg,
  output tbml_pkg::result_t result
);
  import tbml_pkg::*;

  logic [31:0] token_count, token_count_next;
  logic [31:0] last_fill_time, last_fill_time_next;
  logic [31:0] drop_count, drop_count_next;
  logic [31:0] first_drop_time, first_drop_time_next;

  logic        filtered;
  logic        short;
  logic        dropped;
  logic [31:0] elapsed;
  logic [63:0] product;
  logic [31:0] add_sat;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [31:0] refilled;
  logic [31:0] tokens_avail;

  assign filtered = level > cfg.level_cap;
  assign short    = token_count < TOKENS_PER_MESSAGE;

  // saturating rate * elapsed, then saturating add, then clamp to burst
  assign elapsed  = now - last_fill_time;
  assign product  = {32'd0, cfg.refill_rate} * {32'd0, elapsed};
  assign add_sat  = (|product[63:32]) ? '1 : product[31:0];
  assign sum      = {1'b0, token_count} + {1'b0, add_sat};
  assign sum_sat  = sum[32] ? '1 : sum[31:0];
  assign refilled = (sum_sat < cfg.burst_limit) ? sum_sat : cfg.burst_limit;

  always_comb begin
    tokens_avail        = token_count;
    last_fill_time_next = last_fill_time;
    if (short) begin
      if (last_fill_time > now) begin
        tokens_avail = cfg.burst_limit;
      end else if (last_fill_time < now) begin
        tokens_avail        = refilled;
        last_fill_time_next = now;
      end
    end
  end

  assign dropped = short && (tokens_avail < TOKENS_PER_MESSAGE);

  always_comb begin
    token_count_next     = token_count;
    drop_count_next      = drop_count;
    first_drop_time_next = first_drop_time;
    result               = '0;
    result.verdict       = VERDICT_FILTERED;
    if (!filtered) begin
      if (dropped) begin
        token_count_next = tokens_avail;
        if (drop_count == 32'd0) begin
          first_drop_time_next = now;
        end
        drop_count_next = drop_count + 32'd1;
        result.verdict  = VERDICT_DROPPED;
      end else begin
        token_count_next = tokens_avail - TOKENS_PER_MESSAGE;
        result.verdict   = VERDICT_PASSED;
        if (drop_count != 32'd0) begin
          result.report_drops  = 1'b1;
          result.dropped_count = drop_count;
          result.dropped_span  = now - first_drop_time;
          drop_count_next      = 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_count     <= 32'd0;
      last_fill_time  <= '1;
      drop_count      <= 32'd0;
      first_drop_time <= 32'd0;
    end else if (advance && !filtered) begin
      token_count     <= token_count_next;
      last_fill_time  <= last_fill_time_next;
      drop_count      <= drop_count_next;
      first_drop_time <= first_drop_time_next;
    end
  end

endmodule

// ===== design/token_bucket_message_limiter.sv =====
// Pipeline: an accepted item is held in the input register (s1); its result
// is loaded into the output register when the item advances out of s1.
// Throughput: one item per cycle unless res_ready low stalls the output; the
// refill multiply, saturating add and clamp in tbml_core all settle within
// that cycle, and bucket state updates as the item leaves the input register.
// Reset (rst, synchronous): pipeline empty, bucket empty, last fill time all
// ones, drop count zero, registers level cap 7, refill_rate 0, burst_limit 0.
module token_bucket_message_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            msg_valid,
  output logic                            msg_ready,
  input  logic [2:0]                      msg_level,
  input  logic [31:0]                     now_seconds,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [1:0]                      verdict,
  output logic                            report_drops,
  output logic [31:0]                     dropped_count,
  output logic [31:0]                     dropped_span,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbml_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tbml_pkg::*;

  cfg_t        cfg;
  result_t     result;
  logic        s1_valid;
  logic [2:0]  s1_level;
  logic [31:0] s1_now;
  logic        out_free;
  logic        advance;

  assign pready = 1'b1;

  tbml_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign out_free  = !res_valid || res_ready;
  assign advance   = s1_valid && out_free;
  assign msg_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg_ready) begin
      s1_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_valid && msg_ready) begin
      s1_level <= msg_level;
      s1_now   <= now_seconds;
    end
  end

  tbml_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .level   (s1_level),
    .now     (s1_now),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict       <= result.verdict;
      report_drops  <= result.report_drops;
      dropped_count <= result.dropped_count;
      dropped_span  <= result.dropped_span;
    end
  end

  a_report_only_on_pass: assert property (@(posedge clk) disable iff (rst)
    res_valid && report_drops |-> verdict == VERDICT_PASSED && dropped_count != 32'd0)
    else $error("drop report on a non-passing item or with zero count");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && verdict != VERDICT_PASSED |->
      !report_drops && dropped_count == 32'd0 && dropped_span == 32'd0)
    else $error("report fields set on filtered or dropped item");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !res_ready |-> !msg_ready)
    else $error("input accepted while both stages are full");

endmodule
